@@ rtl/core/qsds_pkg.sv @@
// shared types, codes and helpers for the quadrature speed and duty slewer
package qsds_pkg;

    localparam int unsigned POS_W  = 32;
    localparam int unsigned DUTY_W = 8;

    localparam logic [DUTY_W-1:0] DUTY_MAX = 8'hFF;
    localparam logic [DUTY_W-1:0] DUTY_MIN = 8'h00;

    localparam logic [DUTY_W-1:0] DUTY_A_RST = DUTY_MAX;
    localparam logic [DUTY_W-1:0] DUTY_B_RST = DUTY_MIN;

    typedef enum logic
    {
        REQ_SAMPLE = 1'b0,
        REQ_TICK   = 1'b1
    } req_t;

    typedef struct packed
    {
        req_t req_type;
        logic enc_a;
        logic enc_b;
    } item_t;

    typedef struct packed
    {
        logic  valid;
        item_t item;
    } stage_t;

    function automatic logic [DUTY_W-1:0] slew(input logic [DUTY_W-1:0] v, input logic up);
        logic [DUTY_W-1:0] r;
        r = v;
        if (up)
        begin
            if (v != DUTY_MAX)
            begin
                r = v + DUTY_W'(1);
            end
        end
        else
        begin
            if (v != DUTY_MIN)
            begin
                r = v - DUTY_W'(1);
            end
        end
        return r;
    endfunction

endpackage

@@ rtl/core/qsds_in_stage.sv @@
// input register stage holding one accepted item
module qsds_in_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              req_type,
    input  logic              enc_a,
    input  logic              enc_b,
    input  logic              take,
    output qsds_pkg::stage_t  stage
);

    logic            valid_reg;
    logic            valid_next;
    qsds_pkg::item_t item_reg;

    assign in_ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.req_type <= qsds_pkg::req_t'(req_type);
            item_reg.enc_a    <= enc_a;
            item_reg.enc_b    <= enc_b;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

endmodule

@@ rtl/core/qsds_core.sv @@
// decode, slew and speed state, doubling as the result register
module qsds_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [qsds_pkg::POS_W-1:0]    cfg_wdata,
    input  qsds_pkg::stage_t              stage,
    output logic                          take,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [qsds_pkg::POS_W-1:0]    position,
    output logic [qsds_pkg::POS_W-1:0]    speed,
    output logic [qsds_pkg::DUTY_W-1:0]   duty_a,
    output logic [qsds_pkg::DUTY_W-1:0]   duty_b,
    output logic                          drive_on_a
);

    logic                          out_valid_reg,  out_valid_next;
    logic [qsds_pkg::POS_W-1:0]    target_reg;
    logic                          last_a_reg,     last_a_next;
    logic [qsds_pkg::POS_W-1:0]    count_reg,      count_next;
    logic [qsds_pkg::POS_W-1:0]    tick_count_reg, tick_count_next;
    logic [qsds_pkg::POS_W-1:0]    speed_reg,      speed_next;
    logic [qsds_pkg::DUTY_W-1:0]   duty_a_reg,     duty_a_next;
    logic [qsds_pkg::DUTY_W-1:0]   duty_b_reg,     duty_b_next;
    logic                          drive_a_reg,    drive_a_next;
    logic                          step;
    logic                          up;

    assign take = !out_valid_reg || out_ready;
    assign step = stage.valid && take;
    assign up   = $signed(speed_reg) > $signed(target_reg);

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        last_a_next     = last_a_reg;
        count_next      = count_reg;
        tick_count_next = tick_count_reg;
        speed_next      = speed_reg;
        duty_a_next     = duty_a_reg;
        duty_b_next     = duty_b_reg;
        drive_a_next    = drive_a_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (step)
        begin
            out_valid_next = 1'b1;
            case (stage.item.req_type)
                qsds_pkg::REQ_SAMPLE:
                begin
                    // x1 decode on a rising edge of channel a
                    if (stage.item.enc_a && !last_a_reg)
                    begin
                        if (stage.item.enc_b)
                        begin
                            count_next = count_reg - qsds_pkg::POS_W'(1);
                        end
                        else
                        begin
                            count_next = count_reg + qsds_pkg::POS_W'(1);
                        end
                    end
                    last_a_next = stage.item.enc_a;
                end
                qsds_pkg::REQ_TICK:
                begin
                    if (target_reg[qsds_pkg::POS_W-1])
                    begin
                        drive_a_next = 1'b1;
                        duty_a_next  = qsds_pkg::slew(duty_a_reg, up);
                    end
                    else
                    begin
                        drive_a_next = 1'b0;
                        duty_b_next  = qsds_pkg::slew(duty_b_reg, up);
                    end
                    speed_next      = count_reg - tick_count_reg;
                    tick_count_next = count_reg;
                end
                default:
                begin
                    out_valid_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            target_reg     <= '0;
            last_a_reg     <= 1'b1;
            count_reg      <= '0;
            tick_count_reg <= '0;
            speed_reg      <= '0;
            duty_a_reg     <= qsds_pkg::DUTY_A_RST;
            duty_b_reg     <= qsds_pkg::DUTY_B_RST;
            drive_a_reg    <= 1'b1;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                target_reg <= cfg_wdata;
            end
            last_a_reg     <= last_a_next;
            count_reg      <= count_next;
            tick_count_reg <= tick_count_next;
            speed_reg      <= speed_next;
            duty_a_reg     <= duty_a_next;
            duty_b_reg     <= duty_b_next;
            drive_a_reg    <= drive_a_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign position   = count_reg;
    assign speed      = speed_reg;
    assign duty_a     = duty_a_reg;
    assign duty_b     = duty_b_reg;
    assign drive_on_a = drive_a_reg;

endmodule

@@ rtl/core/quadrature_speed_duty_slewer.sv @@
// top level of the quadrature speed and duty slewer
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  in       | in_valid / in_ready  | req_type, enc_a, enc_b
//  out      | out_valid / out_ready| position, speed, duty_a, duty_b, drive_on_a
//  cfg      | cfg_we               | cfg_wdata (target_speed)
//
// one item per cycle sustained while out_ready keeps the result moving; a result passes through
// the input register and then the state register that drives the outputs
// a held result stalls the input register, which still takes one more item
// reset selects channel a with duty_a at its maximum, duty_b at its minimum, position and speed at zero
module quadrature_speed_duty_slewer
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          req_type,
    input  logic                          enc_a,
    input  logic                          enc_b,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [qsds_pkg::POS_W-1:0]    position,
    output logic signed [qsds_pkg::POS_W-1:0] speed,
    output logic [qsds_pkg::DUTY_W-1:0]   duty_a,
    output logic [qsds_pkg::DUTY_W-1:0]   duty_b,
    output logic                          drive_on_a,
    input  logic                          cfg_we,
    input  logic signed [qsds_pkg::POS_W-1:0] cfg_wdata
);

    qsds_pkg::stage_t           stage;
    logic                       take;
    logic [qsds_pkg::POS_W-1:0] speed_u;

    qsds_in_stage u_in_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .req_type (req_type),
        .enc_a    (enc_a),
        .enc_b    (enc_b),
        .take     (take),
        .stage    (stage)
    );

    qsds_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .stage      (stage),
        .take       (take),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .position   (position),
        .speed      (speed_u),
        .duty_a     (duty_a),
        .duty_b     (duty_b),
        .drive_on_a (drive_on_a)
    );

    assign speed = $signed(speed_u);

endmodule

@@ rtl/core/qsds_checker.sv @@
// port-level checks for the quadrature speed and duty slewer, bound to the top level
module qsds_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [qsds_pkg::POS_W-1:0]    position,
    input logic [qsds_pkg::POS_W-1:0]    speed,
    input logic [qsds_pkg::DUTY_W-1:0]   duty_a,
    input logic [qsds_pkg::DUTY_W-1:0]   duty_b
);

    // a stalled item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(position) && $stable(speed))
        else $error("stalled result changed");

    // position moves by at most one count per cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> position == $past(position)
              || position == qsds_pkg::POS_W'($past(position) + qsds_pkg::POS_W'(1))
              || position == qsds_pkg::POS_W'($past(position) - qsds_pkg::POS_W'(1)))
        else $error("position jumped");

    // only one channel slews per item
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> !(duty_a != $past(duty_a) && duty_b != $past(duty_b)))
        else $error("both compare values moved");

    // a new speed comes from a tick, which leaves the position alone
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> speed == $past(speed) || position == $past(position))
        else $error("speed and position changed together");

endmodule

bind quadrature_speed_duty_slewer qsds_checker u_qsds_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .position  (position),
    .speed     (speed),
    .duty_a    (duty_a),
    .duty_b    (duty_b)
);
